FILE: sv/dtdd_pkg.sv
// Shared constants and types for the dihedral tuple duplicate detector.
// No dependencies; used by dtdd_keytab and dihedral_tuple_duplicate_detector.
package dtdd_pkg;

    localparam int TUPLE_LEN      = 6;
    localparam int HASH_COUNT     = 2 * TUPLE_LEN;
    localparam int KEY_BITS       = 64;
    localparam int EPOCH_BITS     = 8;
    localparam int DEF_KEY_ENTRIES = 4096;
    localparam int DEF_ARM_BITS   = 24;

    localparam logic [KEY_BITS-1:0] HASH_BASE = 64'd13131;

    // One slot of the key table: the set generation that wrote it and the key
    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [KEY_BITS-1:0]   key;
    } entry_t;

endpackage

FILE: sv/dtdd_keytab.sv
// Key table memory: one write port, one registered read port.
// Depends on dtdd_pkg for the slot layout.
module dtdd_keytab #(
    parameter int ADDR_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output dtdd_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  dtdd_pkg::entry_t      wr_data
);

    dtdd_pkg::entry_t mem [2**ADDR_BITS];

    // Write slot, register read word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/dihedral_tuple_duplicate_detector.sv
// Top level of the dihedral tuple duplicate detector: hashing, probing control.
// Depends on dtdd_pkg and dtdd_keytab.
//
//  channel | dir | word contents (low bit first)
//  s_axis  | in  | first_of_set, arm0 .. arm5 (ARM_BITS each)
//  m_axis  | out | match_now, match_any, store_overflow
//
// Per word: twelve hashes of six Horner steps (one multiply-add per cycle),
// then two probe passes over the twelve hashes, each table read going through
// ST_ISSUE and ST_CHECK, with extra probes where a slot holds another key.
// Reset starts a clearing pass over all 2**TAB_AW slots (2*KEY_ENTRIES for a power
// of two); the same pass runs again on every 255th first_of_set word when the
// set generation wraps. A word is taken only when idle; while the previous
// result waits on m_tready the next result holds in its last step, and no
// new word is taken until it moves into the output register.
module dihedral_tuple_duplicate_detector #(
    parameter int KEY_ENTRIES = dtdd_pkg::DEF_KEY_ENTRIES,
    parameter int ARM_BITS    = dtdd_pkg::DEF_ARM_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // first_of_set, arm0, arm1, arm2, arm3, arm4, arm5, zero fill
    input  logic [((1 + dtdd_pkg::TUPLE_LEN * ARM_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // match_now, match_any, store_overflow, zero fill
    output logic [7:0]     m_tdata
);

    localparam int TL      = dtdd_pkg::TUPLE_LEN;
    localparam int HC      = dtdd_pkg::HASH_COUNT;
    localparam int KB      = dtdd_pkg::KEY_BITS;
    localparam int EB      = dtdd_pkg::EPOCH_BITS;
    localparam int TAB_AW  = $clog2(2 * KEY_ENTRIES);
    localparam int CNT_W   = $clog2(KEY_ENTRIES + 1);
    localparam int HIDX_W  = $clog2(HC);
    localparam int AIDX_W  = $clog2(TL);

    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(KEY_ENTRIES);
    localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HC - 1);
    localparam logic [HIDX_W-1:0] HIDX_REV  = HIDX_W'(TL);
    localparam logic [AIDX_W-1:0] AIDX_LAST = AIDX_W'(TL - 1);
    localparam logic [AIDX_W-1:0] STEP_LAST = AIDX_W'(TL - 1);
    localparam logic [TAB_AW-1:0] CLR_LAST  = {TAB_AW{1'b1}};
    localparam logic [EB-1:0]     EPOCH_ONE = EB'(1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_ISSUE, ST_CHECK, ST_DONE
    } state_t;

    state_t               state_reg;
    logic [ARM_BITS-1:0]  arm_reg [TL];
    logic [KB-1:0]        hash_reg [HC];
    logic [KB-1:0]        acc_reg;
    logic [HIDX_W-1:0]    hidx_reg;
    logic [AIDX_W-1:0]    step_reg;
    logic [AIDX_W-1:0]    aidx_reg;
    logic                 phase_reg;
    logic [TAB_AW-1:0]    probe_reg;
    logic [TAB_AW-1:0]    clr_reg;
    logic                 pend_reg;
    logic                 hit_reg;
    logic                 match_seen_reg;
    logic                 ovf_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [EB-1:0]        epoch_reg;
    logic                 m_tvalid_reg;
    logic [2:0]           m_data_reg;

    logic [KB-1:0]        acc_next;
    logic [EB-1:0]        epoch_next;
    logic [HIDX_W-1:0]    hidx_next;
    logic [AIDX_W-1:0]    jstart_next;
    logic [AIDX_W-1:0]    aidx_next;
    logic [KB-1:0]        cur_hash;
    logic                 live;
    logic                 same;

    logic                 rd_en;
    dtdd_pkg::entry_t     rd_data;
    logic                 wr_en;
    logic [TAB_AW-1:0]    wr_addr;
    dtdd_pkg::entry_t     wr_data;

    function automatic logic [TAB_AW-1:0] slot_of(input logic [KB-1:0] h);
        slot_of = h[TAB_AW-1:0] ^ h[KB-1 -: TAB_AW];
    endfunction

    dtdd_keytab #(
        .ADDR_BITS (TAB_AW)
    ) u_keytab (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (probe_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Horner step and rotation index bookkeeping
    always_comb begin
        acc_next   = acc_reg * dtdd_pkg::HASH_BASE + KB'(arm_reg[aidx_reg]);
        epoch_next = epoch_reg + EPOCH_ONE;
        hidx_next  = hidx_reg + HIDX_W'(1);
        jstart_next = (hidx_next < HIDX_REV) ? AIDX_W'(hidx_next)
                                             : AIDX_W'(hidx_next - HIDX_REV);
        if (hidx_reg < HIDX_REV) begin
            aidx_next = (aidx_reg == AIDX_LAST) ? '0 : aidx_reg + AIDX_W'(1);
        end else begin
            aidx_next = (aidx_reg == '0) ? AIDX_LAST : aidx_reg - AIDX_W'(1);
        end
        cur_hash = hash_reg[hidx_reg];
        live     = (rd_data.tag == epoch_reg);
        same     = live && (rd_data.key == cur_hash);
    end

    // Table access: read in ST_ISSUE, clearing pass or insert of a new key
    always_comb begin
        rd_en   = (state_reg == ST_ISSUE);
        wr_en   = 1'b0;
        wr_addr = probe_reg;
        wr_data.tag = epoch_reg;
        wr_data.key = cur_hash;
        if (state_reg == ST_CLEAR) begin
            wr_en       = 1'b1;
            wr_addr     = clr_reg;
            wr_data.tag = '0;
            wr_data.key = '0;
        end else if (state_reg == ST_CHECK && phase_reg && !live
                     && count_reg != CNT_FULL) begin
            wr_en = 1'b1;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    // Sequencer: accept, hash, look up, insert, report
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            match_seen_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            count_reg      <= '0;
            epoch_reg      <= '0;
            phase_reg      <= 1'b0;
            hidx_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + TAB_AW'(1);
                    if (clr_reg == CLR_LAST) begin
                        epoch_reg <= EPOCH_ONE;
                        state_reg <= pend_reg ? ST_HASH : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        for (int i = 0; i < TL; i++) begin
                            arm_reg[i] <= s_tdata[1 + i * ARM_BITS +: ARM_BITS];
                        end
                        hidx_reg  <= '0;
                        step_reg  <= '0;
                        aidx_reg  <= '0;
                        acc_reg   <= '0;
                        hit_reg   <= 1'b0;
                        phase_reg <= 1'b0;
                        pend_reg  <= 1'b1;
                        state_reg <= (s_tdata[0] && epoch_next == '0) ? ST_CLEAR
                                                                      : ST_HASH;
                        if (s_tdata[0]) begin
                            match_seen_reg <= 1'b0;
                            ovf_reg        <= 1'b0;
                            count_reg      <= '0;
                            epoch_reg      <= epoch_next;
                            clr_reg        <= '0;
                        end
                    end
                end
                ST_HASH: begin
                    pend_reg <= 1'b0;
                    if (step_reg == STEP_LAST) begin
                        hash_reg[hidx_reg] <= acc_next;
                        step_reg <= '0;
                        acc_reg  <= '0;
                        if (hidx_reg == HIDX_LAST) begin
                            hidx_reg  <= '0;
                            probe_reg <= slot_of(hash_reg[0]);
                            state_reg <= ST_ISSUE;
                        end else begin
                            hidx_reg <= hidx_next;
                            aidx_reg <= jstart_next;
                        end
                    end else begin
                        acc_reg  <= acc_next;
                        step_reg <= step_reg + AIDX_W'(1);
                        aidx_reg <= aidx_next;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (same || !live) begin
                        if (!phase_reg && same) begin
                            hit_reg <= 1'b1;
                        end
                        if (phase_reg && !live) begin
                            if (count_reg == CNT_FULL) begin
                                ovf_reg <= 1'b1;
                            end else begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                        // advance to the next hash, the next pass or the result
                        if (hidx_reg == HIDX_LAST) begin
                            hidx_reg <= '0;
                            if (!phase_reg) begin
                                phase_reg <= 1'b1;
                                probe_reg <= slot_of(hash_reg[0]);
                                state_reg <= ST_ISSUE;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end else begin
                            hidx_reg  <= hidx_next;
                            probe_reg <= slot_of(hash_reg[hidx_next]);
                            state_reg <= ST_ISSUE;
                        end
                    end else begin
                        probe_reg <= probe_reg + TAB_AW'(1);
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg   <= 1'b1;
                        m_data_reg     <= {ovf_reg, match_seen_reg | hit_reg, hit_reg};
                        match_seen_reg <= match_seen_reg | hit_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for dihedral_tuple_duplicate_detector: drives tuple words,
// predicts match and overflow flags with a local hash/key-set model.
// Depends on dtdd_pkg and the detector RTL.
module tb_top;

    localparam int TUPLE_LEN  = dtdd_pkg::TUPLE_LEN;
    localparam int HASH_COUNT = dtdd_pkg::HASH_COUNT;
    localparam int ENTRIES  = dtdd_pkg::DEF_KEY_ENTRIES;
    localparam int ABITS    = dtdd_pkg::DEF_ARM_BITS;
    localparam int DW       = ((1 + TUPLE_LEN * ABITS + 7) / 8) * 8;
    localparam logic [63:0] BASE = 64'd13131;

    typedef struct packed {
        logic [ABITS-1:0] a5, a4, a3, a2, a1, a0;
        logic             first;
    } tuple_t;

    typedef struct packed {
        logic ovf;
        logic any;
        logic now;
    } flags_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [7:0]    m_tdata;

    dihedral_tuple_duplicate_detector DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Key set model
    logic [63:0] keys[$];
    bit          seen_match, seen_ovf;
    tuple_t      pending_words[$];
    flags_t      expected_flags[$];
    int          errors = 0;
    bit          stim_done = 1'b0;
    bit          hold_sender = 1'b0;
    bit          quiet = 1'b0;
    int          hold_off = 0;
    int          sent_count = 0;
    int          results_seen = 0;
    bit          held = 1'b0;

    function automatic bit key_known(logic [63:0] k);
        foreach (keys[i]) if (keys[i] == k) return 1'b1;
        return 1'b0;
    endfunction

    function automatic flags_t predict_flags(tuple_t w);
        logic [ABITS-1:0] arm[TUPLE_LEN];
        logic [63:0]      h[HASH_COUNT];
        logic [63:0]      f, r;
        bit               hit;
        flags_t           res;
        hit = 1'b0;
        arm[0] = w.a0; arm[1] = w.a1; arm[2] = w.a2;
        arm[3] = w.a3; arm[4] = w.a4; arm[5] = w.a5;
        if (w.first) begin
            keys.delete();
            seen_match = 1'b0;
            seen_ovf = 1'b0;
        end
        for (int j = 0; j < TUPLE_LEN; j++) begin
            f = '0;
            r = '0;
            for (int k = 0; k < TUPLE_LEN; k++) begin
                f = f * BASE + 64'(arm[(j + k) % TUPLE_LEN]);
                r = r * BASE + 64'(arm[(j - k + TUPLE_LEN) % TUPLE_LEN]);
            end
            h[j] = f;
            h[TUPLE_LEN + j] = r;
        end
        // look up all, then insert
        for (int j = 0; j < HASH_COUNT; j++) if (key_known(h[j])) hit = 1'b1;
        for (int j = 0; j < HASH_COUNT; j++) begin
            if (!key_known(h[j])) begin
                if (keys.size() >= ENTRIES) seen_ovf = 1'b1;
                else keys.push_back(h[j]);
            end
        end
        if (hit) seen_match = 1'b1;
        res.now = hit;
        res.any = seen_match;
        res.ovf = seen_ovf;
        return res;
    endfunction

    function automatic logic [ABITS-1:0] rnd_arm(int pool);
        case ($urandom_range(0, 3))
            0: return ABITS'($urandom_range(0, pool));
            1: return {ABITS{1'b1}} - ABITS'($urandom_range(0, pool));
            default: return ABITS'($urandom);
        endcase
    endfunction

    function automatic tuple_t rnd_word(bit first, int pool);
        tuple_t w;
        w.first = first;
        w.a0 = rnd_arm(pool); w.a1 = rnd_arm(pool); w.a2 = rnd_arm(pool);
        w.a3 = rnd_arm(pool); w.a4 = rnd_arm(pool); w.a5 = rnd_arm(pool);
        return w;
    endfunction

    // Rotate or reverse a tuple so it should match its source
    function automatic tuple_t twist(tuple_t w);
        logic [ABITS-1:0] a[TUPLE_LEN];
        logic [ABITS-1:0] b[TUPLE_LEN];
        int               s;
        bit               rv;
        tuple_t           o;
        a[0] = w.a0; a[1] = w.a1; a[2] = w.a2; a[3] = w.a3; a[4] = w.a4; a[5] = w.a5;
        s = $urandom_range(0, 5);
        rv = 1'($urandom_range(0, 1));
        for (int i = 0; i < TUPLE_LEN; i++)
            b[i] = rv ? a[(s - i + TUPLE_LEN) % TUPLE_LEN] : a[(s + i) % TUPLE_LEN];
        o.first = 1'b0;
        o.a0 = b[0]; o.a1 = b[1]; o.a2 = b[2]; o.a3 = b[3]; o.a4 = b[4]; o.a5 = b[5];
        return o;
    endfunction

    // Stimulus
    initial begin
        tuple_t w, base_w;
        tuple_t hist[$];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: extremes, symmetric tuples, rotations, reversals
        w = '0; w.first = 1'b1; pending_words.push_back(w);
        w = '0; pending_words.push_back(w);
        w = '1; pending_words.push_back(w);
        w = '1; w.first = 1'b0; pending_words.push_back(w);
        w = '0; w.first = 1'b1; w.a0 = 1; w.a1 = 2; w.a2 = 3; w.a3 = 4; w.a4 = 5;
        w.a5 = 6; pending_words.push_back(w); base_w = w;
        for (int i = 0; i < 6; i++) pending_words.push_back(twist(base_w));
        w = '0; w.a0 = 7; w.a1 = 8; w.a2 = 7; w.a3 = 8; w.a4 = 7; w.a5 = 8;
        w.first = 1'b1; pending_words.push_back(w);
        w.first = 1'b0; w.a0 = 8; w.a1 = 7; w.a2 = 8; w.a3 = 7; w.a4 = 8; w.a5 = 7;
        pending_words.push_back(w);
        w = rnd_word(1'b1, 3); pending_words.push_back(w);
        pending_words.push_back(twist(w));
        pending_words.push_back(rnd_word(1'b0, 3));
        // random sets: fresh words, twisted repeats, occasional new set
        for (int n = 0; n < 1250; n++) begin
            if (n == 400) begin
                // pause until drained
                wait (pending_words.size() == 0 && expected_flags.size() == 0);
                hold_sender = 1'b1;
                repeat (30) @(posedge aclk);
                hold_sender = 1'b0;
            end
            if (n == 900) begin
                // long single set to fill the key store past overflow
                w = rnd_word(1'b1, 1000);
                pending_words.push_back(w);
                for (int i = 0; i < 360; i++) pending_words.push_back(rnd_word(1'b0, 1000));
                n += 360;
                continue;
            end
            if ($urandom_range(0, 29) == 0 || n == 0) begin
                hist.delete();
                w = rnd_word(1'b1, 5);
            end else if (hist.size() > 0 && $urandom_range(0, 2) == 0)
                w = twist(hist[$urandom_range(0, hist.size() - 1)]);
            else
                w = rnd_word(1'b0, 5);
            hist.push_back(w);
            pending_words.push_back(w);
        end
        stim_done = 1'b1;
    end

    // Driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_flags.push_back(predict_flags(pending_words.pop_front()));
                sent_count++;
                // run both sides without idling over a stretch of words
                quiet = (sent_count >= 600) && (sent_count < 750);
            end
            if ((!s_tvalid || s_tready) || !s_tvalid) begin
                if (s_tvalid && !s_tready) begin
                    // hold current word
                end else if (pending_words.size() > (s_tvalid && s_tready ? 0 : 0)
                             && !hold_sender
                             && (quiet || $urandom_range(0, 99) >= 37)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= DW'(pending_words[0]);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        flags_t got, exp_f;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[2:0];
                results_seen++;
                if (expected_flags.size() == 0) begin
                    $display("%0t: unexpected result %b", $realtime, got);
                    errors++;
                end else begin
                    exp_f = expected_flags.pop_front();
                    if (got.now !== exp_f.now || got.any !== exp_f.any
                        || got.ovf !== exp_f.ovf) begin
                        $display("%0t: flags mismatch expected %b actual %b",
                                 $realtime, exp_f, got);
                        errors++;
                    end
                end
            end
            // receiver back-pressure: one long hold-off, otherwise random
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (!held && results_seen >= 200) begin
                held = 1'b1;
                hold_off = 3000;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    // End of run
    initial begin
        wait (stim_done && pending_words.size() == 0 && !s_tvalid);
        wait (expected_flags.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_flags.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dtdd_pkg.sv
sv/dtdd_keytab.sv
sv/dihedral_tuple_duplicate_detector.sv
sim/tb_top.sv
